// ===== src/vector_angle_degrees_assert.svh =====
// Assertion macros shared by the vector angle RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef VECTOR_ANGLE_DEGREES_ASSERT_SVH
`define VECTOR_ANGLE_DEGREES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VAD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vector_angle_degrees assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vector_angle_degrees assertion failed");

`endif

// ===== src/vad_pkg.sv =====
// Shared types, constants and the arctangent table for the vector angle block.
// No dependencies; used by every module under src.
package vad_pkg;

    localparam int COMPONENT_BITS      = 16;
    localparam int ANGLE_FRACTION_BITS = 7;
    localparam int ROTATION_STAGES     = 16;

    localparam int ANGLE_W   = 16;                  // output field width
    localparam int ZFRAC     = 24;                  // fraction bits of the angle accumulator
    localparam int TABLE_LEN = 32;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int CW        = 64;                  // rotation datapath width
    localparam int PRE_SHIFT = 60 - COMPONENT_BITS;
    localparam int ZW        = 32;                  // accumulator width, signed
    localparam int AW        = 34;                  // folded angle width, unsigned
    localparam int ROUND_SH  = ZFRAC - ANGLE_FRACTION_BITS;

    localparam logic [8:0] DEG_0   = 9'd0;
    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_270 = 9'd270;

    localparam logic signed [ZW-1:0] Z_90  = ZW'(64'd90 << ZFRAC);
    localparam logic [AW-1:0] A_90         = AW'(64'd90 << ZFRAC);
    localparam logic [AW-1:0] A_180        = AW'(64'd180 << ZFRAC);
    localparam logic [AW-1:0] A_360        = AW'(64'd360 << ZFRAC);
    localparam logic [AW-1:0] ROUND_HALF   = AW'(64'd1 << (ROUND_SH - 1));
    localparam logic [AW-1:0] ANGLE_FULL   = AW'(64'd360 << ANGLE_FRACTION_BITS);

    typedef struct packed {
        logic               special;        // axis case, angle already known
        logic [ANGLE_W-1:0] special_angle;
        logic               x_neg;
        logic               y_neg;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        side_t                side;
    } cell_t;

    // Whole degrees to the output format, truncated to the field width.
    function automatic logic [ANGLE_W-1:0] deg_out(input logic [8:0] deg);
        logic [63:0] t;
        t = 64'(deg) << ANGLE_FRACTION_BITS;
        return t[ANGLE_W-1:0];
    endfunction

    // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_deg(input logic [IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd754974720;
            5'd1:  v = 32'sd445687602;
            5'd2:  v = 32'sd235489088;
            5'd3:  v = 32'sd119537938;
            5'd4:  v = 32'sd60000934;
            5'd5:  v = 32'sd30029717;
            5'd6:  v = 32'sd15018523;
            5'd7:  v = 32'sd7509720;
            5'd8:  v = 32'sd3754917;
            5'd9:  v = 32'sd1877466;
            5'd10: v = 32'sd938734;
            5'd11: v = 32'sd469367;
            5'd12: v = 32'sd234684;
            5'd13: v = 32'sd117342;
            5'd14: v = 32'sd58671;
            5'd15: v = 32'sd29335;
            5'd16: v = 32'sd14668;
            5'd17: v = 32'sd7334;
            5'd18: v = 32'sd3667;
            5'd19: v = 32'sd1833;
            5'd20: v = 32'sd917;
            5'd21: v = 32'sd458;
            5'd22: v = 32'sd229;
            5'd23: v = 32'sd115;
            5'd24: v = 32'sd57;
            5'd25: v = 32'sd29;
            5'd26: v = 32'sd14;
            5'd27: v = 32'sd7;
            5'd28: v = 32'sd4;
            5'd29: v = 32'sd2;
            5'd30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/vad_prep.sv =====
// Input cell: magnitudes, axis detection and scaling into the rotation format.
// Depends on vad_pkg.
module vad_prep (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      up_valid,
    output logic                                      up_ready,
    input  logic signed [vad_pkg::COMPONENT_BITS-1:0] vec_x,
    input  logic signed [vad_pkg::COMPONENT_BITS-1:0] vec_y,
    output logic                                      dn_valid,
    input  logic                                      dn_ready,
    output vad_pkg::cell_t                            dn_data
);

    localparam int N = vad_pkg::COMPONENT_BITS;

    logic                 valid_reg;
    vad_pkg::cell_t       data_reg;
    vad_pkg::cell_t       data_next;
    logic signed [N:0]    xe;
    logic signed [N:0]    ye;
    logic [N:0]           ax;
    logic [N:0]           ay;
    logic [vad_pkg::CW-1:0] ax_w;
    logic [vad_pkg::CW-1:0] ay_w;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        xe   = {vec_x[N-1], vec_x};
        ye   = {vec_y[N-1], vec_y};
        // one extra bit so the most negative value has an exact magnitude
        ax   = xe[N] ? (N+1)'(-xe) : (N+1)'(xe);
        ay   = ye[N] ? (N+1)'(-ye) : (N+1)'(ye);
        ax_w = vad_pkg::CW'(ax) << vad_pkg::PRE_SHIFT;
        ay_w = vad_pkg::CW'(ay) << vad_pkg::PRE_SHIFT;

        data_next.x          = signed'(ax_w);
        data_next.y          = signed'(ay_w);
        data_next.z          = '0;
        data_next.side.x_neg = vec_x[N-1];
        data_next.side.y_neg = vec_y[N-1];
        if (vec_x == '0) begin
            data_next.side.special       = 1'b1;
            data_next.side.special_angle = vec_y[N-1] ? vad_pkg::deg_out(vad_pkg::DEG_270)
                                                      : vad_pkg::deg_out(vad_pkg::DEG_90);
        end else if (vec_y == '0) begin
            data_next.side.special       = 1'b1;
            data_next.side.special_angle = vec_x[N-1] ? vad_pkg::deg_out(vad_pkg::DEG_180)
                                                      : vad_pkg::deg_out(vad_pkg::DEG_0);
        end else begin
            data_next.side.special       = 1'b0;
            data_next.side.special_angle = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/vad_cell.sv =====
// One vectoring rotation cell: shift-add step on x/y and table step on the angle.
// Depends on vad_pkg; stage_idx is tied to a constant per instance.
module vad_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [vad_pkg::IDX_W-1:0]     stage_idx,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  vad_pkg::cell_t                up_data,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output vad_pkg::cell_t                dn_data
);

    logic                          valid_reg;
    vad_pkg::cell_t                data_reg;
    vad_pkg::cell_t                data_next;
    logic signed [vad_pkg::CW-1:0] xs;
    logic signed [vad_pkg::CW-1:0] ys;
    logic signed [vad_pkg::ZW-1:0] step;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        // arithmetic shift floors, as the rotation step requires
        xs   = up_data.x >>> stage_idx;
        ys   = up_data.y >>> stage_idx;
        step = vad_pkg::atan_deg(stage_idx);
        data_next.side = up_data.side;
        if (!up_data.y[vad_pkg::CW-1]) begin
            data_next.x = up_data.x + ys;
            data_next.y = up_data.y - xs;
            data_next.z = up_data.z + step;
        end else begin
            data_next.x = up_data.x - ys;
            data_next.y = up_data.y + xs;
            data_next.z = up_data.z - step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/vad_fold.sv =====
// Output cells: saturate and fold into the quadrant, then round, wrap and hold the result.
// Depends on vad_pkg.
module vad_fold (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  vad_pkg::cell_t                 up_data,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output logic [vad_pkg::ANGLE_W-1:0]    dn_angle
);

    localparam int AW = vad_pkg::AW;

    logic                           fold_valid_reg;
    logic [AW-1:0]                  fold_reg;
    logic [AW-1:0]                  fold_next;
    vad_pkg::side_t                 side_reg;
    logic                           fold_ready;
    logic [AW-1:0]                  zs;
    logic                           out_valid_reg;
    logic [vad_pkg::ANGLE_W-1:0]    out_reg;
    logic [vad_pkg::ANGLE_W-1:0]    out_next;
    logic [AW-1:0]                  rnd;

    assign up_ready   = !fold_valid_reg || fold_ready;
    assign fold_ready = !out_valid_reg || dn_ready;
    assign dn_valid   = out_valid_reg;
    assign dn_angle   = out_reg;

    // first stage: clamp to [0, 90] and place in the quadrant
    always_comb begin
        if (up_data.z[vad_pkg::ZW-1]) begin
            zs = '0;
        end else if (up_data.z > vad_pkg::Z_90) begin
            zs = vad_pkg::A_90;
        end else begin
            zs = AW'(unsigned'(up_data.z));
        end
        case ({up_data.side.x_neg, up_data.side.y_neg})
            2'b00:   fold_next = zs;
            2'b10:   fold_next = vad_pkg::A_180 - zs;
            2'b11:   fold_next = vad_pkg::A_180 + zs;
            default: fold_next = vad_pkg::A_360 - zs;
        endcase
    end

    // second stage: round half up, wrap 360 to 0, or take the known angle for an axis case
    always_comb begin
        rnd = (fold_reg + vad_pkg::ROUND_HALF) >> vad_pkg::ROUND_SH;
        if (rnd >= vad_pkg::ANGLE_FULL) begin
            rnd = rnd - vad_pkg::ANGLE_FULL;
        end
        out_next = side_reg.special ? side_reg.special_angle : rnd[vad_pkg::ANGLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (up_ready) begin
                fold_valid_reg <= up_valid;
            end
            if (fold_ready) begin
                out_valid_reg <= fold_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            fold_reg <= fold_next;
            side_reg <= up_data.side;
        end
        if (fold_ready && fold_valid_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== src/vector_angle_degrees.sv =====
// Top level: four-quadrant vector angle in degrees from a chain of rotation cells.
// Depends on vad_pkg, vad_prep, vad_cell, vad_fold and vector_angle_degrees_assert.svh.
//
//   channel   direction   tdata fields (low bit first)
//   s_        in          vec_x[15:0], vec_y[31:16]
//   m_        out         angle_deg[15:0]
//
// One transaction per cycle sustained while m_tready stays high; the registers in order are
// the input cell, one cell per rotation stage, the fold cell and the output register.
// Every cell holds its own valid bit, so bubbles close up under a stall and
// s_tready stays high while the input cell is empty.
// aresetn (synchronous) clears the valid bits only.
`include "vector_angle_degrees_assert.svh"

module vector_angle_degrees (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // vec_x [15:0], vec_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // angle_deg [15:0]
);

    localparam int NS = vad_pkg::ROTATION_STAGES;
    localparam int NC = vad_pkg::COMPONENT_BITS;

    vad_pkg::cell_t chain_data  [NS+1];
    logic           chain_valid [NS+1];
    logic           chain_ready [NS+1];

    vad_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .vec_x    (signed'(s_tdata[NC-1:0])),
        .vec_y    (signed'(s_tdata[2*NC-1:NC])),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_data  (chain_data[0])
    );

    for (genvar i = 0; i < NS; i++) begin : g_cell
        vad_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (vad_pkg::IDX_W'(i)),
            .up_valid  (chain_valid[i]),
            .up_ready  (chain_ready[i]),
            .up_data   (chain_data[i]),
            .dn_valid  (chain_valid[i+1]),
            .dn_ready  (chain_ready[i+1]),
            .dn_data   (chain_data[i+1])
        );
    end

    vad_fold u_fold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (chain_valid[NS]),
        .up_ready (chain_ready[NS]),
        .up_data  (chain_data[NS]),
        .dn_valid (m_tvalid),
        .dn_ready (m_tready),
        .dn_angle (m_tdata)
    );

    `VAD_ASSERT_SAME(a_out_range, aclk, aresetn, m_tvalid, vad_pkg::AW'(m_tdata) < vad_pkg::ANGLE_FULL)
    `VAD_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !chain_valid[0], s_tready)
    `VAD_ASSERT_NEXT(a_prep_loads, aclk, aresetn, s_tvalid && s_tready, chain_valid[0])
    `VAD_ASSERT_NEXT(a_zero_x_special, aclk, aresetn, s_tvalid && s_tready && (s_tdata[NC-1:0] == '0), chain_data[0].side.special)

endmodule

// ===== dv/vector_angle_degrees_test.sv =====
// Self-checking testbench for vector_angle_degrees: directed axis, extreme and quadrant vectors,
// then random vectors under several idle and stall patterns, checked against a CORDIC predictor.
// Depends on vad_pkg and the vector_angle_degrees RTL under src.
module vector_angle_degrees_test;

    localparam int LATENCY = vad_pkg::ROTATION_STAGES + 3;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [15:0]        angle;
    } angle_entry_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // vec_x [15:0], vec_y [31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // angle_deg [15:0]

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;

    angle_entry_t angle_q [$];

    // atan(2^-i) in degrees, Q24, rounded to nearest
    longint atan_q24 [32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    vector_angle_degrees dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [15:0] predict_angle(input logic signed [15:0] vx,
                                                  input logic signed [15:0] vy);
        longint x, y, z, xs, ys, a, r;
        int     sh;
        sh = vad_pkg::ZFRAC - vad_pkg::ANGLE_FRACTION_BITS;
        if (vx == 0) begin
            r = (vy < 0) ? (longint'(270) << vad_pkg::ANGLE_FRACTION_BITS)
                         : (longint'(90) << vad_pkg::ANGLE_FRACTION_BITS);
            return r[15:0];
        end
        if (vy == 0) begin
            r = (vx < 0) ? (longint'(180) << vad_pkg::ANGLE_FRACTION_BITS) : 0;
            return r[15:0];
        end
        x = (vx < 0) ? -longint'(vx) : longint'(vx);
        y = (vy < 0) ? -longint'(vy) : longint'(vy);
        x = x <<< (60 - vad_pkg::COMPONENT_BITS);
        y = y <<< (60 - vad_pkg::COMPONENT_BITS);
        z = 0;
        for (int i = 0; i < vad_pkg::ROTATION_STAGES && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q24[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q24[i];
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) <<< vad_pkg::ZFRAC)) z = longint'(90) <<< vad_pkg::ZFRAC;
        if (vx > 0 && vy > 0)
            a = z;
        else if (vx < 0 && vy > 0)
            a = (longint'(180) <<< vad_pkg::ZFRAC) - z;
        else if (vx < 0)
            a = (longint'(180) <<< vad_pkg::ZFRAC) + z;
        else
            a = (longint'(360) <<< vad_pkg::ZFRAC) - z;
        r = (a + (longint'(1) <<< (sh - 1))) >>> sh;
        // a result that rounds up to a full turn wraps to zero
        if (r >= (longint'(360) <<< vad_pkg::ANGLE_FRACTION_BITS))
            r = r - (longint'(360) <<< vad_pkg::ANGLE_FRACTION_BITS);
        return r[15:0];
    endfunction

    // Result side: check first, then record the accepted vector
    always @(posedge aclk) begin
        angle_entry_t exp_e, new_e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (angle_q.size() == 0) begin
                    $error("angle_deg: result with no vector pending, got %0d", m_tdata);
                    error_count++;
                end else begin
                    exp_e = angle_q.pop_front();
                    if (m_tdata !== exp_e.angle) begin
                        $error("angle_deg mismatch (x=%0d y=%0d): expected %0d, got %0d",
                               exp_e.vx, exp_e.vy, exp_e.angle, m_tdata);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                new_e.vx    = s_tdata[15:0];
                new_e.vy    = s_tdata[31:16];
                new_e.angle = predict_angle(new_e.vx, new_e.vy);
                angle_q.push_back(new_e);
            end
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Called at a falling edge; returns at a falling edge after the transaction and any gap.
    task automatic send_vector(input logic signed [15:0] vx, input logic signed [15:0] vy);
        s_tdata  <= {vy, vx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    // Hold off the sender until every pending angle has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (angle_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_random_vectors(input int count);
        int kind, t;
        logic signed [15:0] vx, vy;
        logic signed [15:0] corner [6] = '{-16'sd32768, -16'sd32767, -16'sd1,
                                           16'sd0, 16'sd1, 16'sd32767};
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            vx = 16'($urandom);
            vy = 16'($urandom);
            case (kind)
                6: begin
                    t = $urandom_range(6); vx = 16'(t - 3);
                    t = $urandom_range(6); vy = 16'(t - 3);
                end
                7: begin
                    t = $urandom_range(6); vx = 16'(t - 3);
                end
                8: begin
                    t = $urandom_range(6); vy = 16'(t - 3);
                end
                9: begin
                    vx = corner[$urandom_range(5)];
                    if ($urandom_range(1)) vy = corner[$urandom_range(5)];
                end
                default: ;
            endcase
            send_vector(vx, vy);
        end
    endtask

    task automatic test_axis_vectors();
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sd5);
        send_vector(16'sd0, -16'sd5);
        send_vector(16'sd0, 16'sd32767);
        send_vector(16'sd0, -16'sd32768);
        send_vector(16'sd5, 16'sd0);
        send_vector(-16'sd5, 16'sd0);
        send_vector(16'sd32767, 16'sd0);
        send_vector(-16'sd32768, 16'sd0);
    endtask

    task automatic test_extreme_components();
        send_vector(-16'sd32768, -16'sd32768);
        send_vector(16'sd32767, 16'sd32767);
        send_vector(-16'sd32768, 16'sd32767);
        send_vector(16'sd32767, -16'sd32768);
        send_vector(16'sd1, 16'sd32767);
        send_vector(-16'sd1, -16'sd32768);
        send_vector(-16'sd32768, 16'sd1);
    endtask

    task automatic test_quadrants_and_wrap();
        send_vector(16'sd1, 16'sd1);
        send_vector(-16'sd1, 16'sd1);
        send_vector(-16'sd1, -16'sd1);
        send_vector(16'sd1, -16'sd1);
        send_vector(16'sd32767, 16'sd1);
        // just below a full turn, rounds up and wraps to zero
        send_vector(16'sd32767, -16'sd1);
        send_vector(-16'sd32768, -16'sd1);
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_vectors(400);
        wait_for_drain();
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 80;
        recv_stall_pct = 0;
        run_random_vectors(350);
        wait_for_drain();
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        run_random_vectors(350);
        wait_for_drain();
    endtask

    task automatic test_light_idling();
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        run_random_vectors(350);
        wait_for_drain();
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_axis_vectors();
        test_extreme_components();
        test_quadrants_and_wrap();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_light_idling();
        recv_stall_pct = 0;
        repeat (LATENCY + 8) @(posedge aclk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/vad_pkg.sv
src/vad_prep.sv
src/vad_cell.sv
src/vad_fold.sv
src/vector_angle_degrees.sv
dv/vector_angle_degrees_test.sv
